### hdl/sitda_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds widths, character codes, the FSM state type and the cell control struct.
// No dependencies.
`default_nettype none

package sitda_pkg;

   localparam int VALUE_W       = 32;
   localparam int MAX_DIGITS    = 10;
   localparam int DIGIT_W       = 4;
   localparam int CHAR_W        = 6;
   localparam int BITS_PER_STEP = 4;
   localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
   localparam int CONV_CNT_W    = $clog2(CONV_STEPS);
   localparam int DIGIT_CNT_W   = $clog2(MAX_DIGITS + 1);
   localparam int REQ_DATA_W    = ((VALUE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W    = ((CHAR_W + 7) / 8) * 8;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
   localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } state_type;

   // Command to every cell of the digit row; clear wins over the others.
   typedef struct packed {
      logic clear;
      logic convert;
      logic shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

### hdl/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII converter.
// Instantiates a row of sitda_cell digit cells; depends on sitda_pkg.
//
// Usage:
//   req channel: one transaction per 32-bit signed value (req_tdata[31:0]).
//   rsp channel: one transaction per character; rsp_tdata[5:0] holds the
//   ASCII code ('-' or '0'..'9'), rsp_tlast marks the final character.
//   A negative value starts with '-', digits follow most significant first,
//   zero gives a single '0'.
// Timing: the value is accepted in idle, its magnitude is shifted into a
//   row of MAX_DIGITS BCD cells four bits per cycle, then the row shifts up
//   one digit per cycle while the output register can take a character,
//   leading zeros dropped. The '-' is loaded during conversion if the output
//   register is free, else before the first digit. req_tready is high only
//   between values.
// Reset: synchronous, active high; returns to idle and drops any character
//   waiting on rsp.
// Stall: a one-entry output register holds a character while rsp_tready is
//   low; the digit row stops shifting until the register frees up.
`default_nettype none

module signed_int_to_decimal_ascii
   import sitda_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] value
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,   // [5:0] character, [7:6] zero
   output logic                       rsp_tlast    // last_char
);

   state_type                state_ff, state_in;
   logic [VALUE_W-1:0]       mag_ff, mag_in;
   logic                     sign_pend_ff, sign_pend_in;
   logic                     started_ff, started_in;
   logic [CONV_CNT_W-1:0]    conv_cnt_ff, conv_cnt_in;
   logic [DIGIT_CNT_W-1:0]   remain_ff, remain_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]        rsp_char_ff, rsp_char_in;
   logic                     rsp_last_ff, rsp_last_in;

   cell_ctrl_type            cell_ctrl;
   logic                     req_accept;
   logic                     slot_free;
   logic                     sign_load;
   logic                     digit_step;
   logic                     conv_done;
   logic                     last_digit;
   logic                     emit_now;
   logic [DIGIT_W-1:0]       top_digit;
   logic [VALUE_W-1:0]       in_value;

   logic [BITS_PER_STEP-1:0] carry_chain [MAX_DIGITS+1];
   logic [DIGIT_W-1:0]       digit_chain [MAX_DIGITS];

   // ---------------------------------------------------------------
   // Digit row: cell 0 takes magnitude bits, carries ripple upward.
   // ---------------------------------------------------------------
   genvar g;
   generate
      for (g = 0; g < BITS_PER_STEP; g++) begin : g_feed
         assign carry_chain[0][g] = mag_ff[VALUE_W-1-g];
      end
   endgenerate

   generate
      for (g = 0; g < MAX_DIGITS; g++) begin : g_cell
         if (g == 0) begin : g_bottom
            sitda_cell u_cell (
               .clock       (clock),
               .ctrl        (cell_ctrl),
               .carry_in    (carry_chain[g]),
               .lower_digit ({DIGIT_W{1'b0}}),
               .carry_out   (carry_chain[g+1]),
               .digit_out   (digit_chain[g])
            );
         end else begin : g_upper
            sitda_cell u_cell (
               .clock       (clock),
               .ctrl        (cell_ctrl),
               .carry_in    (carry_chain[g]),
               .lower_digit (digit_chain[g-1]),
               .carry_out   (carry_chain[g+1]),
               .digit_out   (digit_chain[g])
            );
         end
      end
   endgenerate

   assign top_digit = digit_chain[MAX_DIGITS-1];

   // ---------------------------------------------------------------
   // Control
   // ---------------------------------------------------------------
   assign in_value   = req_tdata[VALUE_W-1:0];
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign conv_done  = (conv_cnt_ff == CONV_CNT_W'(CONV_STEPS - 1));
   assign last_digit = (remain_ff == DIGIT_CNT_W'(1));
   // Skip leading zeros, but always keep the units digit.
   assign emit_now   = started_ff || (top_digit != '0) || last_digit;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free && !sign_pend_ff && last_digit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs
   always_comb begin
      req_tready        = 1'b0;
      cell_ctrl.clear   = 1'b0;
      cell_ctrl.convert = 1'b0;
      cell_ctrl.shift   = 1'b0;
      digit_step        = 1'b0;
      sign_load         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready      = 1'b1;
            cell_ctrl.clear = req_tvalid;
         end
         ST_CONV: begin
            cell_ctrl.convert = 1'b1;
            sign_load         = sign_pend_ff && slot_free;
         end
         ST_EMIT: begin
            sign_load       = sign_pend_ff && slot_free;
            digit_step      = slot_free && !sign_pend_ff;
            cell_ctrl.shift = digit_step;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      mag_in       = mag_ff;
      sign_pend_in = sign_pend_ff;
      started_in   = started_ff;
      conv_cnt_in  = conv_cnt_ff;
      remain_in    = remain_ff;

      if (req_accept) begin
         // Unsigned negate keeps the most negative value exact.
         mag_in       = in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;
         sign_pend_in = in_value[VALUE_W-1];
         started_in   = 1'b0;
         conv_cnt_in  = '0;
         remain_in    = DIGIT_CNT_W'(MAX_DIGITS);
      end

      if (cell_ctrl.convert) begin
         mag_in      = mag_ff << BITS_PER_STEP;
         conv_cnt_in = conv_cnt_ff + CONV_CNT_W'(1);
         // A carry out of the top cell means digits were dropped: print all cells.
         started_in  = started_ff || (carry_chain[MAX_DIGITS] != '0);
      end

      if (sign_load) begin
         sign_pend_in = 1'b0;
      end

      if (digit_step) begin
         remain_in  = remain_ff - DIGIT_CNT_W'(1);
         started_in = started_ff || (top_digit != '0);
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (sign_load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = CHAR_MINUS;
         rsp_last_in  = 1'b0;
      end else if (digit_step && emit_now) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = CHAR_ZERO + CHAR_W'(top_digit);
         rsp_last_in  = last_digit;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sign_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sign_pend_ff <= sign_pend_in;
      end
   end

   // Payload and counters, qualified by the state machine
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      started_ff  <= started_in;
      conv_cnt_ff <= conv_cnt_in;
      remain_ff   <= remain_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_char_ff);
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

### hdl/sitda_cell.sv
// One BCD digit cell of the conversion row.
// Runs BITS_PER_STEP shift-and-add-3 steps per cycle, shifts its digit up, or clears.
// Depends on sitda_pkg.
`default_nettype none

module sitda_cell
   import sitda_pkg::*;
(
   input  wire logic                     clock,
   input  wire cell_ctrl_type            ctrl,
   input  wire logic [BITS_PER_STEP-1:0] carry_in,    // bit 0 enters first
   input  wire logic [DIGIT_W-1:0]       lower_digit,
   output logic      [BITS_PER_STEP-1:0] carry_out,
   output logic      [DIGIT_W-1:0]       digit_out
);

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] conv_value;

   // Adjust by three at five or more, then shift in the neighbor's bit.
   always_comb begin
      logic [DIGIT_W-1:0] v;
      logic [DIGIT_W-1:0] adj;
      v = digit_ff;
      carry_out = '0;
      for (int j = 0; j < BITS_PER_STEP; j++) begin
         adj = (v >= DIGIT_W'(5)) ? v + DIGIT_W'(3) : v;
         carry_out[j] = adj[DIGIT_W-1];
         v = {adj[DIGIT_W-2:0], carry_in[j]};
      end
      conv_value = v;
   end

   always_comb begin
      digit_in = digit_ff;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.convert) begin
         digit_in = conv_value;
      end else if (ctrl.shift) begin
         digit_in = lower_digit;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit_out = digit_ff;

endmodule

`default_nettype wire

### hdl/sitda_checker.sv
// Port-level checker for signed_int_to_decimal_ascii, bound to the top level.
// Depends on sitda_pkg.
`default_nettype none

module sitda_checker
   import sitda_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [REQ_DATA_W-1:0] req_tdata,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tlast
);

   // A stalled character holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   // One value at a time: no new value right after one is taken.
   a_one_value: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted back to back");

   // Only '-' and decimal digits leave.
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == RSP_DATA_W'(CHAR_MINUS)) ||
         ((rsp_tdata >= RSP_DATA_W'(CHAR_ZERO)) &&
          (rsp_tdata <= RSP_DATA_W'(CHAR_ZERO) + RSP_DATA_W'(9))))
      else $error("rsp character out of range");

   // A sign is never the end of a run.
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata == RSP_DATA_W'(CHAR_MINUS)) |-> !rsp_tlast)
      else $error("minus sign flagged as last");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (.*);

`default_nettype wire
